@@ rtl/cbq_pkg.sv @@
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types, constants and the coefficient design functions of the
// cabinet biquad cascade. The functions are only evaluated at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package cbq_pkg;

    localparam int GUARD_BITS = 8;
    localparam int ACC_EXTRA  = 16;
    localparam int NUM_SEC    = 4;
    localparam int SEC_W      = 2;
    localparam int NUM_K      = 5;
    localparam int CIDX_W     = 5;
    localparam int MODEL_W    = 2;
    localparam int MIC_W      = 7;
    localparam int LP_W       = 8;
    localparam int NUM_MODEL  = 3;
    localparam int NUM_MIC    = 101;
    localparam int NUM_LP     = 161;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [MODEL_W-1:0] MODEL_MAX = 2'd2;
    localparam logic [MIC_W-1:0]   MIC_MAX   = 7'd100;
    localparam logic [MIC_W-1:0]   MIC_RESET = 7'd50;

    // coefficient order inside one section
    localparam logic [2:0] CK_B0 = 3'd0;
    localparam logic [2:0] CK_B1 = 3'd1;
    localparam logic [2:0] CK_B2 = 3'd2;
    localparam logic [2:0] CK_A1 = 3'd3;
    localparam logic [2:0] CK_A2 = 3'd4;

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_MODEL  = 2'd1,
        REG_MIC    = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        STEP_B0X,
        STEP_B1X,
        STEP_B2X,
        STEP_A1Y,
        STEP_A2Y,
        STEP_UPD
    } t_step;

    typedef struct packed {
        logic             load;
        logic             run;
        logic [SEC_W-1:0] sec;
        t_step            step;
        logic             emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

    typedef struct packed {
        longint c;
        longint s;
    } t_cs;

    typedef struct packed {
        longint b0;
        longint b1;
        longint b2;
        longint a1;
        longint a2;
    } t_cq;

    localparam int     QK          = 30;
    localparam longint Q_ONE       = 64'sd1 <<< QK;
    localparam longint PI_Q        = 64'sd3373259426;
    localparam longint INV_SQRT2_Q = 64'sd759250125;
    localparam longint LN10_Q      = 64'sd2472381918;

    // shift-subtract division, rounding is done by the callers
    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        if (d == 0) begin
            return 0;
        end
        for (int i = 63; i >= 0; i--) begin
            r = (r << 1) | longint'(n[i]);
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint with_sign(bit neg, longint unsigned m);
        longint r;
        r = longint'(m);
        return neg ? -r : r;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint unsigned m;
        m = (mag(a) * mag(b) + (64'd1 << (QK - 1))) >> QK;
        return with_sign((a < 0) != (b < 0), m);
    endfunction

    function automatic longint qdiv(longint n, longint d);
        longint unsigned dm;
        dm = mag(d);
        if (dm == 0) begin
            return 0;
        end
        return with_sign((n < 0) != (d < 0), udiv((mag(n) << QK) + (dm >> 1), dm));
    endfunction

    function automatic longint idiv(longint n, longint unsigned d);
        if (d == 0) begin
            return 0;
        end
        return with_sign(n < 0, udiv(mag(n) + (d >> 1), d));
    endfunction

    function automatic longint rsh(longint v, int s);
        if (s == 0) begin
            return v;
        end
        return with_sign(v < 0, (mag(v) + (64'd1 << (s - 1))) >> s);
    endfunction

    // cos and sin of 2*pi*tn/td, for tn up to td/2 (cos -1, sin 0 beyond)
    function automatic t_cs trig(longint unsigned tn, longint unsigned td);
        t_cs             res;
        bit              flip;
        longint unsigned n;
        longint          y, y2, ts, tc, ss, cc;
        longint unsigned d1, d2;
        flip = 1'b0;
        if (2 * tn > td) begin
            n    = 0;
            flip = 1'b1;
        end else if (4 * tn > td) begin
            n    = td - 2 * tn;
            flip = 1'b1;
        end else begin
            n = 2 * tn;
        end
        y  = idiv(PI_Q * longint'(n), td);
        y2 = qmul(y, y);
        ts = y;
        ss = y;
        tc = Q_ONE;
        cc = Q_ONE;
        for (int k = 1; k <= 8; k++) begin
            d1 = longint'((2 * k) * (2 * k + 1));
            d2 = longint'((2 * k - 1) * (2 * k));
            ts = -idiv(qmul(ts, y2), d1);
            tc = -idiv(qmul(tc, y2), d2);
            ss = ss + ts;
            cc = cc + tc;
        end
        res.c = flip ? -cc : cc;
        res.s = ss;
        return res;
    endfunction

    // 10^(dB/40) with dB/40 = k/d
    function automatic longint gain_amp(longint k, longint unsigned d);
        longint e, term, sum;
        e    = idiv(LN10_Q * k, d);
        term = Q_ONE;
        sum  = Q_ONE;
        for (int i = 1; i <= 12; i++) begin
            term = idiv(qmul(term, e), longint'(i));
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic t_cq store(int cfb, longint b0, longint b1, longint b2,
                                  longint a1, longint a2);
        t_cq r;
        r.b0 = rsh(b0, QK - cfb);
        r.b1 = rsh(b1, QK - cfb);
        r.b2 = rsh(b2, QK - cfb);
        r.a1 = rsh(a1, QK - cfb);
        r.a2 = rsh(a2, QK - cfb);
        return r;
    endfunction

    function automatic t_cq pass_coef(bit high, longint unsigned tn, longint unsigned td,
                                      int cfb);
        t_cs    t;
        longint a, a0, h;
        t  = trig(tn, td);
        a  = qmul(t.s, INV_SQRT2_Q);
        a0 = Q_ONE + a;
        h  = high ? Q_ONE + t.c : Q_ONE - t.c;
        return store(cfb, qdiv(idiv(h, 2), a0), qdiv(high ? -h : h, a0),
                     qdiv(idiv(h, 2), a0), qdiv(-2 * t.c, a0), qdiv(Q_ONE - a, a0));
    endfunction

    function automatic t_cq peak_coef(longint unsigned hz, longint a_num,
                                      longint unsigned a_den, longint gk,
                                      longint unsigned gd, longint unsigned fs, int cfb);
        t_cs    t;
        longint a, amp, aa, ad, a0, b1;
        t   = trig(hz, fs);
        a   = idiv(t.s * a_num, a_den);
        amp = gain_amp(gk, gd);
        aa  = qmul(a, amp);
        ad  = qdiv(a, amp);
        a0  = Q_ONE + ad;
        b1  = qdiv(-2 * t.c, a0);
        return store(cfb, qdiv(Q_ONE + aa, a0), b1, qdiv(Q_ONE - aa, a0), b1,
                     qdiv(Q_ONE - ad, a0));
    endfunction

    function automatic t_cq coef_hp(int m, longint unsigned fs, int cfb);
        longint unsigned hz;
        case (m)
            0:       hz = 95;
            1:       hz = 80;
            default: hz = 70;
        endcase
        return pass_coef(1'b1, hz, fs, cfb);
    endfunction

    function automatic t_cq coef_body(int m, longint unsigned fs, int cfb);
        longint unsigned hz;
        case (m)
            0:       hz = 170;
            1:       hz = 140;
            default: hz = 115;
        endcase
        return peak_coef(hz, 5, 9, longint'(4 + 3 * m), 80, fs, cfb);
    endfunction

    function automatic t_cq coef_pres(int mic, longint unsigned fs, int cfb);
        return peak_coef(3500, 1, 2, longint'(3 * (mic - 50)), 1000, fs, cfb);
    endfunction

    // low-pass corner table runs from 4000 Hz in 20 Hz steps
    function automatic t_cq coef_lp(int j, longint unsigned fs, int cfb);
        longint f;
        f = longint'(4000 + 20 * j);
        if (f < 100) begin
            return pass_coef(1'b0, 100, fs, cfb);
        end else if (20 * f > 9 * longint'(fs)) begin
            return pass_coef(1'b0, 9, 20, cfb);
        end
        return pass_coef(1'b0, longint'(f), fs, cfb);
    endfunction

endpackage

`default_nettype wire

@@ rtl/cbq_coef_rom.sv @@
// ----------------------------------------------------------------------------
// cbq_coef_rom
// Coefficient tables built at elaboration and the registered coefficient
// bank selected by cabinet model and mic position.
// ----------------------------------------------------------------------------
`default_nettype none

module cbq_coef_rom #(
    parameter int SAMPLE_RATE    = 48000,
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic                                     i_clk,
    input  wire logic [cbq_pkg::MODEL_W-1:0]              i_model,
    input  wire logic [cbq_pkg::MIC_W-1:0]                i_mic,
    output logic [cbq_pkg::NUM_SEC*cbq_pkg::NUM_K-1:0][COEF_FRAC_BITS+3:0] o_coef
);

    localparam int CW = COEF_FRAC_BITS + 4;
    localparam longint unsigned FS = longint'(SAMPLE_RATE);

    cbq_pkg::t_cq w_hp   [cbq_pkg::NUM_MODEL];
    cbq_pkg::t_cq w_body [cbq_pkg::NUM_MODEL];
    cbq_pkg::t_cq w_pres [cbq_pkg::NUM_MIC];
    cbq_pkg::t_cq w_lp   [cbq_pkg::NUM_LP];

    for (genvar g = 0; g < cbq_pkg::NUM_MODEL; g++) begin : g_model
        localparam cbq_pkg::t_cq HP   = cbq_pkg::coef_hp(g, FS, COEF_FRAC_BITS);
        localparam cbq_pkg::t_cq BODY = cbq_pkg::coef_body(g, FS, COEF_FRAC_BITS);
        assign w_hp[g]   = HP;
        assign w_body[g] = BODY;
    end

    for (genvar g = 0; g < cbq_pkg::NUM_MIC; g++) begin : g_mic
        localparam cbq_pkg::t_cq PRES = cbq_pkg::coef_pres(g, FS, COEF_FRAC_BITS);
        assign w_pres[g] = PRES;
    end

    for (genvar g = 0; g < cbq_pkg::NUM_LP; g++) begin : g_lp
        localparam cbq_pkg::t_cq LP = cbq_pkg::coef_lp(g, FS, COEF_FRAC_BITS);
        assign w_lp[g] = LP;
    end

    logic [1:0]                    w_mdl;
    logic [cbq_pkg::MIC_W-1:0]     w_mic;
    logic [cbq_pkg::LP_W-1:0]      w_lp_base;
    logic [cbq_pkg::LP_W-1:0]      w_lp_idx;
    cbq_pkg::t_cq                  w_sel [cbq_pkg::NUM_SEC];

    // clamp out-of-range codes
    assign w_mdl = (i_model > cbq_pkg::MODEL_MAX) ? cbq_pkg::MODEL_MAX : i_model;
    assign w_mic = (i_mic > cbq_pkg::MIC_MAX) ? cbq_pkg::MIC_MAX : i_mic;

    // low-pass corner = base + 20*(mic-50), base 6200/5600/5000 Hz
    always_comb begin
        case (w_mdl)
            2'd0:    w_lp_base = 8'd60;
            2'd1:    w_lp_base = 8'd30;
            default: w_lp_base = 8'd0;
        endcase
    end
    assign w_lp_idx = w_lp_base + cbq_pkg::LP_W'(w_mic);

    assign w_sel[0] = w_hp[w_mdl];
    assign w_sel[1] = w_body[w_mdl];
    assign w_sel[2] = w_pres[w_mic];
    assign w_sel[3] = w_lp[w_lp_idx];

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < cbq_pkg::NUM_SEC; s++) begin
            o_coef[s*cbq_pkg::NUM_K + 0] <= CW'(w_sel[s].b0);
            o_coef[s*cbq_pkg::NUM_K + 1] <= CW'(w_sel[s].b1);
            o_coef[s*cbq_pkg::NUM_K + 2] <= CW'(w_sel[s].b2);
            o_coef[s*cbq_pkg::NUM_K + 3] <= CW'(w_sel[s].a1);
            o_coef[s*cbq_pkg::NUM_K + 4] <= CW'(w_sel[s].a2);
        end
    end

endmodule

`default_nettype wire

@@ rtl/cbq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbq_ctrl
// Sequencer: walks the four sections through six MAC steps each (or skips
// them with enable low) and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_enable,
    input  wire cbq_pkg::t_dp_sts i_sts,
    output logic                  o_ready,
    output cbq_pkg::t_dp_cmd      o_cmd
);

    cbq_pkg::t_state                r_state, n_state;
    logic [cbq_pkg::SEC_W-1:0]      r_sec, n_sec;
    cbq_pkg::t_step                 r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbq_pkg::ST_IDLE;
            r_sec   <= '0;
            r_step  <= cbq_pkg::STEP_B0X;
        end else begin
            r_state <= n_state;
            r_sec   <= n_sec;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sec      = r_sec;
        n_step     = r_step;
        o_ready    = 1'b0;
        o_cmd      = '0;
        o_cmd.sec  = r_sec;
        o_cmd.step = r_step;
        case (r_state)
            cbq_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_sec      = '0;
                    n_step     = cbq_pkg::STEP_B0X;
                    // bypass goes straight to the output
                    n_state    = i_enable ? cbq_pkg::ST_RUN : cbq_pkg::ST_EMIT;
                end
            end
            cbq_pkg::ST_RUN: begin
                o_cmd.run = 1'b1;
                case (r_step)
                    cbq_pkg::STEP_B0X: n_step = cbq_pkg::STEP_B1X;
                    cbq_pkg::STEP_B1X: n_step = cbq_pkg::STEP_B2X;
                    cbq_pkg::STEP_B2X: n_step = cbq_pkg::STEP_A1Y;
                    cbq_pkg::STEP_A1Y: n_step = cbq_pkg::STEP_A2Y;
                    cbq_pkg::STEP_A2Y: n_step = cbq_pkg::STEP_UPD;
                    default: begin
                        n_step = cbq_pkg::STEP_B0X;
                        n_sec  = r_sec + 1'b1;
                        if (r_sec == cbq_pkg::SEC_W'(cbq_pkg::NUM_SEC - 1)) begin
                            n_state = cbq_pkg::ST_EMIT;
                        end
                    end
                endcase
            end
            cbq_pkg::ST_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = cbq_pkg::ST_IDLE;
                end
            end
            default: n_state = cbq_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/cbq_datapath.sv @@
// ----------------------------------------------------------------------------
// cbq_datapath
// Shared multiplier, rounding, section delays and the output register of
// the transposed direct form II cascade.
// ----------------------------------------------------------------------------
`default_nettype none

module cbq_datapath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire cbq_pkg::t_dp_cmd                      i_cmd,
    input  wire logic [cbq_pkg::NUM_SEC*cbq_pkg::NUM_K-1:0][COEF_FRAC_BITS+3:0] i_coef,
    input  wire logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]              o_sample,
    output cbq_pkg::t_dp_sts                           o_sts
);

    localparam int CW = COEF_FRAC_BITS + 4;
    localparam int PW = CW + SAMPLE_BITS;
    localparam int SH = COEF_FRAC_BITS - cbq_pkg::GUARD_BITS;
    localparam int AB = SAMPLE_BITS + cbq_pkg::ACC_EXTRA;
    localparam int EW = AB + 3;

    localparam logic signed [PW:0]   P_HALF = (PW+1)'(1) << (SH - 1);
    localparam logic signed [EW-1:0] Y_HALF = EW'(1) << (cbq_pkg::GUARD_BITS - 1);
    localparam logic signed [EW-1:0] Y_MAX  = EW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] Y_MIN  = -Y_MAX - EW'(1);
    localparam logic signed [EW-1:0] Z_MAX  = EW'((64'sd1 <<< (AB - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] Z_MIN  = -Z_MAX - EW'(1);

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [PW-1:0]          r_prod;
    logic signed [EW-1:0]          r_acc;
    logic signed [EW-1:0]          r_t;
    logic signed [AB-1:0]          r_z0 [cbq_pkg::NUM_SEC];
    logic signed [AB-1:0]          r_z1 [cbq_pkg::NUM_SEC];
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic [2:0]                    w_k;
    logic [cbq_pkg::CIDX_W-1:0]    w_cidx;
    logic signed [CW-1:0]          w_coef;
    logic signed [SAMPLE_BITS-1:0] w_opnd;
    logic signed [PW-1:0]          w_mul;
    logic signed [PW:0]            w_pr_sum;
    logic signed [PW:0]            w_pr_sh;
    logic signed [EW-1:0]          w_pr;
    logic signed [EW-1:0]          w_y_sum;
    logic signed [EW-1:0]          w_y_sh;
    logic signed [SAMPLE_BITS-1:0] w_y;
    logic signed [EW-1:0]          w_z0_in;
    logic signed [EW-1:0]          w_z1_in;

    function automatic logic signed [AB-1:0] sat_acc(logic signed [EW-1:0] v);
        if (v > Z_MAX) begin
            return Z_MAX[AB-1:0];
        end else if (v < Z_MIN) begin
            return Z_MIN[AB-1:0];
        end
        return v[AB-1:0];
    endfunction

    always_comb begin
        case (i_cmd.step)
            cbq_pkg::STEP_B0X: w_k = cbq_pkg::CK_B0;
            cbq_pkg::STEP_B1X: w_k = cbq_pkg::CK_B1;
            cbq_pkg::STEP_B2X: w_k = cbq_pkg::CK_B2;
            cbq_pkg::STEP_A1Y: w_k = cbq_pkg::CK_A1;
            cbq_pkg::STEP_A2Y: w_k = cbq_pkg::CK_A2;
            default:           w_k = cbq_pkg::CK_B0;
        endcase
    end

    assign w_cidx = cbq_pkg::CIDX_W'(i_cmd.sec) * cbq_pkg::CIDX_W'(cbq_pkg::NUM_K)
                  + cbq_pkg::CIDX_W'(w_k);
    assign w_coef = i_coef[w_cidx];
    assign w_opnd = (i_cmd.step == cbq_pkg::STEP_A1Y || i_cmd.step == cbq_pkg::STEP_A2Y)
                  ? r_y : r_x;
    assign w_mul  = w_coef * w_opnd;

    // round the last product to nearest, ties away from zero
    assign w_pr_sum = $signed({r_prod[PW-1], r_prod}) + P_HALF
                    - $signed({{PW{1'b0}}, r_prod[PW-1]});
    assign w_pr_sh  = w_pr_sum >>> SH;
    assign w_pr     = EW'(w_pr_sh);

    // section output: drop the guard bits and saturate
    assign w_y_sum = r_acc + Y_HALF - $signed({{(EW-1){1'b0}}, r_acc[EW-1]});
    assign w_y_sh  = w_y_sum >>> cbq_pkg::GUARD_BITS;
    assign w_y     = (w_y_sh > Y_MAX) ? Y_MAX[SAMPLE_BITS-1:0]
                   : (w_y_sh < Y_MIN) ? Y_MIN[SAMPLE_BITS-1:0]
                   : w_y_sh[SAMPLE_BITS-1:0];

    assign w_z0_in = r_acc - w_pr;
    assign w_z1_in = r_t - w_pr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample;
        end
        if (i_cmd.run) begin
            r_prod <= w_mul;
            case (i_cmd.step)
                cbq_pkg::STEP_B1X: r_acc <= w_pr + EW'(r_z0[i_cmd.sec]);
                cbq_pkg::STEP_B2X: begin
                    r_y   <= w_y;
                    r_acc <= w_pr + EW'(r_z1[i_cmd.sec]);
                end
                cbq_pkg::STEP_A1Y: r_t <= w_pr;
                cbq_pkg::STEP_UPD: r_x <= r_y;
                default: ;
            endcase
        end
        if (i_cmd.emit) begin
            r_out <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < cbq_pkg::NUM_SEC; s++) begin
                r_z0[s] <= '0;
                r_z1[s] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.run && i_cmd.step == cbq_pkg::STEP_A2Y) begin
                r_z0[i_cmd.sec] <= sat_acc(w_z0_in);
            end
            if (i_cmd.run && i_cmd.step == cbq_pkg::STEP_UPD) begin
                r_z1[i_cmd.sec] <= sat_acc(w_z1_in);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_out;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

@@ rtl/cabinet_biquad_cascade.sv @@
// ----------------------------------------------------------------------------
// cabinet_biquad_cascade
// Speaker cabinet filter: high-pass, body peak, mic presence peak and
// low-pass biquads in series on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: i_valid/o_ready with i_sample_in. Output beat: o_valid/i_ready
//   with o_sample_out. Configuration goes through the APB port: enable at
//   0x0, cabinet model at 0x4, mic position at 0x8; write it only while idle.
//   Each accepted sample runs through 4 sections x 6 steps of the one
//   multiplier and is then loaded into the output register, which raises
//   o_valid; o_ready stays low until that load, so one sample is in flight
//   at a time. With enable low the sample is copied to the output register
//   without the multiplier, and the delays hold.
//   The coefficient bank is registered from the ROM behind the registers.
//   A stalled receiver holds the result in the output register; the next
//   sample is still accepted and computed, then waits for that register.
//   Reset (synchronous, active low) clears the section delays, enables
//   filtering, selects model 0 and mic position 50.
// ----------------------------------------------------------------------------
`default_nettype none

module cabinet_biquad_cascade #(
    parameter int SAMPLE_RATE    = 48000,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_sample_in,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [SAMPLE_BITS-1:0]             o_sample_out,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [cbq_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [cbq_pkg::DATA_W-1:0]           pwdata,
    output logic [cbq_pkg::DATA_W-1:0]                prdata,
    output logic                                      pready
);

    logic                           r_enable;
    logic [cbq_pkg::MODEL_W-1:0]    r_model;
    logic [cbq_pkg::MIC_W-1:0]      r_mic;
    logic                           w_wr;
    cbq_pkg::t_reg_idx              w_idx;

    logic [cbq_pkg::NUM_SEC*cbq_pkg::NUM_K-1:0][COEF_FRAC_BITS+3:0] w_coef;
    cbq_pkg::t_dp_cmd               w_cmd;
    cbq_pkg::t_dp_sts               w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = cbq_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_model  <= '0;
            r_mic    <= cbq_pkg::MIC_RESET;
        end else if (w_wr) begin
            case (w_idx)
                cbq_pkg::REG_ENABLE: r_enable <= pwdata[0];
                cbq_pkg::REG_MODEL:  r_model  <= pwdata[cbq_pkg::MODEL_W-1:0];
                cbq_pkg::REG_MIC:    r_mic    <= pwdata[cbq_pkg::MIC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cbq_pkg::REG_ENABLE: prdata = cbq_pkg::DATA_W'(r_enable);
            cbq_pkg::REG_MODEL:  prdata = cbq_pkg::DATA_W'(r_model);
            cbq_pkg::REG_MIC:    prdata = cbq_pkg::DATA_W'(r_mic);
            default:             prdata = '0;
        endcase
    end

    cbq_coef_rom #(
        .SAMPLE_RATE    (SAMPLE_RATE),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_model (r_model),
        .i_mic   (r_mic),
        .o_coef  (w_coef)
    );

    cbq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_enable (r_enable),
        .i_sts    (w_sts),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    cbq_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_coef      (w_coef),
        .i_sample    (i_sample_in),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_sample    (o_sample_out),
        .o_sts       (w_sts)
    );

    // one sample in flight: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while a sample is in flight");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_valid)
        else $error("emitted result not presented");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !(o_valid && !i_ready))
        else $error("output register overwritten while stalled");

    a_no_run_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (!w_cmd.run && !w_cmd.emit))
        else $error("datapath active while idle");

endmodule

`default_nettype wire
